// ===== design/stfm_pkg.sv =====
// package for the sorted table first-match search block
// holds widths, request and status codes, fsm state type and control structs
// no dependencies
package stfm_pkg;

  // payload widths of the request and result channels
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 16;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 12;
  localparam int COUNT_W  = 13;

  // default table geometry
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_KEY_BITS    = 16;

  // request action codes
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SEARCH,
    S_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // latch request, init search bounds
    logic probe;   // first memory read at the middle of the range
    logic step;    // compare, narrow range, issue next read
    logic finish;  // commit state update and load result register
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_query;     // latched request is a query
    logic range_empty;  // search range holds no entry
    logic step_done;    // this step closes the search range
  } dp_stat_t;

endpackage

// ===== design/stfm_in_if.sv =====
// request channel interface: valid/ready handshake with action and key
// depends on stfm_pkg
interface stfm_in_if;
  logic                       valid;
  logic                       ready;
  logic [stfm_pkg::ACTION_W-1:0] action;
  logic [stfm_pkg::KEY_W-1:0]    key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

// ===== design/stfm_out_if.sv =====
// result channel interface: valid/ready handshake with search results
// depends on stfm_pkg
interface stfm_out_if;
  logic                          valid;
  logic                          ready;
  logic [stfm_pkg::STATUS_W-1:0] status;
  logic [stfm_pkg::INDEX_W-1:0]  first_index;
  logic [stfm_pkg::COUNT_W-1:0]  run_to_end;
  logic [stfm_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output first_index,
                  output run_to_end, output entry_count, input ready);
  modport sink   (input valid, input status, input first_index,
                  input run_to_end, input entry_count, output ready);
endinterface

// ===== design/stfm_ctrl.sv =====
// controller fsm for the first-match search: sequences request intake,
// binary search probes and result hand-off; depends on stfm_pkg
module stfm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  stfm_pkg::dp_stat_t   stat,
  output stfm_pkg::ctrl_cmd_t  cmd
);
  import stfm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result register can take a new result when empty or being drained
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.is_query ? S_START : S_FINISH;
        end
      end
      S_START: begin
        state_nxt = stat.range_empty ? S_FINISH : S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.step_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START: begin
        cmd.probe = !stat.range_empty;
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/stfm_dpath.sv =====
// datapath for the first-match search: key memory, fill count, last key,
// search bounds and result register; depends on stfm_pkg
module stfm_dpath #(
  parameter int TABLE_DEPTH = stfm_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = stfm_pkg::DEF_KEY_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [stfm_pkg::ACTION_W-1:0] in_action,
  input  logic [stfm_pkg::KEY_W-1:0]    in_key,
  input  stfm_pkg::ctrl_cmd_t           cmd,
  output stfm_pkg::dp_stat_t            stat,
  output logic [stfm_pkg::STATUS_W-1:0] out_status,
  output logic [stfm_pkg::INDEX_W-1:0]  out_first_index,
  output logic [stfm_pkg::COUNT_W-1:0]  out_run_to_end,
  output logic [stfm_pkg::COUNT_W-1:0]  out_entry_count
);
  import stfm_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // key memory, valid only below the fill count
  logic [KEY_BITS-1:0] mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0] rdata_r;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  // control state
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [KEY_BITS-1:0] last_key_r, last_key_nxt;

  // request and search registers
  logic [ACTION_W-1:0] action_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [CNT_W-1:0]    mid_r, mid_nxt;

  // result register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [INDEX_W-1:0]  res_first_r, res_first_nxt;
  logic [COUNT_W-1:0]  res_run_r, res_run_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;

  logic [31:0]         key_ext;
  logic [CNT_W:0]      init_sum;
  logic [CNT_W-1:0]    init_mid;
  logic                key_lt;
  logic [CNT_W-1:0]    step_lo;
  logic [CNT_W-1:0]    step_hi;
  logic [CNT_W:0]      step_sum;
  logic [CNT_W-1:0]    step_mid;
  logic                step_more;
  logic                hit;
  logic [31:0]         lo_ext;
  logic [31:0]         run_ext;
  logic [31:0]         fill_ext;

  // key limited to the configured key width
  assign key_ext = 32'(in_key);

  // middle of the initial range
  assign init_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign init_mid = init_sum[CNT_W:1];

  // one search step: narrow range by the probed key, pick next probe
  assign key_lt    = rdata_r < key_r;
  assign step_lo   = key_lt ? mid_r + CNT_W'(1) : lo_r;
  assign step_hi   = key_lt ? hi_r : mid_r;
  assign step_sum  = {1'b0, step_lo} + {1'b0, step_hi};
  assign step_mid  = step_sum[CNT_W:1];
  assign step_more = step_lo < step_hi;

  // status to controller
  assign stat.is_query    = (cmd.load ? in_action : action_r) == ACT_QUERY;
  assign stat.range_empty = !(lo_r < hi_r);
  assign stat.step_done   = !step_more;

  // search bounds and memory read address
  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    mem_re    = 1'b0;
    mem_raddr = init_mid[ADDR_W-1:0];
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = fill_r;
    end else if (cmd.probe) begin
      mid_nxt   = init_mid;
      mem_re    = 1'b1;
      mem_raddr = init_mid[ADDR_W-1:0];
    end else if (cmd.step) begin
      lo_nxt  = step_lo;
      hi_nxt  = step_hi;
      mid_nxt = step_mid;
      mem_re  = 1'b1;
      // last step reads the lower bound for the equality check
      mem_raddr = step_more ? step_mid[ADDR_W-1:0] : step_lo[ADDR_W-1:0];
    end
  end

  // commit and result
  assign hit      = (lo_r < fill_r) && (rdata_r == key_r);
  assign lo_ext   = 32'(lo_r);
  assign run_ext  = 32'(fill_r - lo_r);

  always_comb begin
    fill_nxt       = fill_r;
    last_key_nxt   = last_key_r;
    mem_we         = 1'b0;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    res_run_nxt    = res_run_r;
    if (cmd.finish) begin
      res_status_nxt = ST_OK;
      res_first_nxt  = '0;
      res_run_nxt    = '0;
      case (action_r)
        ACT_APPEND: begin
          if (fill_r == DEPTH_CNT) begin
            res_status_nxt = ST_FULL;
          end else if (key_r < last_key_r) begin
            res_status_nxt = ST_ORDER;
          end else begin
            mem_we       = 1'b1;
            fill_nxt     = fill_r + CNT_W'(1);
            last_key_nxt = key_r;
          end
        end
        ACT_QUERY: begin
          if (hit) begin
            res_first_nxt = lo_ext[INDEX_W-1:0];
            res_run_nxt   = run_ext[COUNT_W-1:0];
          end else begin
            res_status_nxt = ST_MISS;
          end
        end
        ACT_CLEAR: begin
          fill_nxt     = '0;
          last_key_nxt = '0;
        end
        default: begin
          res_status_nxt = ST_OK;
        end
      endcase
    end
  end

  assign fill_ext      = 32'(fill_nxt);
  assign res_count_nxt = cmd.finish ? fill_ext[COUNT_W-1:0] : res_count_r;

  // key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[ADDR_W-1:0]] <= key_r;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      last_key_r <= '0;
    end else begin
      fill_r     <= fill_nxt;
      last_key_r <= last_key_nxt;
    end
  end

  // request, search and result payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      key_r    <= key_ext[KEY_BITS-1:0];
    end
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    res_run_r    <= res_run_nxt;
    res_count_r  <= res_count_nxt;
  end

  assign out_status      = res_status_r;
  assign out_first_index = res_first_r;
  assign out_run_to_end  = res_run_r;
  assign out_entry_count = res_count_r;

endmodule

// ===== design/sorted_table_first_match_search.sv =====
// Sorted key table with first-match search. An append request stores a key
// at the end of the table (refused when full or when smaller than the last
// key), a query request finds the first entry equal to the key by a
// lower-bound binary search and returns its index and the count of entries
// from there to the end, and a clear request empties the table. Every
// request gives exactly one result, and requests are served one at a time.
// Append, clear and unused codes need no search. A query makes between 1 and
// ceil(log2(n + 1)) probes for n stored entries (none when empty); the key
// memory's single read port gives one probe per cycle. A finished result
// waits in an output register, and the next request is taken while it
// waits; it only stalls completion of that next request. No clearing pass
// is needed after reset.
// depends on stfm_pkg, stfm_in_if, stfm_out_if, stfm_ctrl, stfm_dpath
module sorted_table_first_match_search #(
  parameter int TABLE_DEPTH = stfm_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = stfm_pkg::DEF_KEY_BITS
) (
  input  logic clk,
  input  logic rst_n,
  stfm_in_if.sink    in_ch,
  stfm_out_if.source out_ch
);
  import stfm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // request sequencing
  stfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table storage and search datapath
  stfm_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_ch.action),
    .in_key          (in_ch.key),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_ch.status),
    .out_first_index (out_ch.first_index),
    .out_run_to_end  (out_ch.run_to_end),
    .out_entry_count (out_ch.entry_count)
  );

endmodule

// ===== design/stfm_checker.sv =====
// port-level checker for the first-match search block, bound to the top
// depends on stfm_pkg
module stfm_checker #(
  parameter int TABLE_DEPTH = stfm_pkg::DEF_TABLE_DEPTH
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [stfm_pkg::STATUS_W-1:0] out_status,
  input logic [stfm_pkg::INDEX_W-1:0]  out_first_index,
  input logic [stfm_pkg::COUNT_W-1:0]  out_run_to_end,
  input logic [stfm_pkg::COUNT_W-1:0]  out_entry_count
);
  import stfm_pkg::*;

  // result fields only fit unclipped up to this depth
  localparam bit FITS = TABLE_DEPTH <= 4096;
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(TABLE_DEPTH);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_first_index) && $stable(out_run_to_end)
      && $stable(out_entry_count))
    else $error("result changed while stalled");

  // a miss reports no range
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISS |->
      out_first_index == '0 && out_run_to_end == '0)
    else $error("miss with nonzero range");

  // a hit range ends exactly at the table end
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    FITS && out_valid && out_status == ST_OK && out_run_to_end != '0 |->
      (COUNT_W'(out_first_index) + out_run_to_end) == out_entry_count)
    else $error("hit range does not reach table end");

  // a refused full append only with the table full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    FITS && out_valid && out_status == ST_FULL |-> out_entry_count == DEPTH_CNT)
    else $error("full status with table not full");

  // entry count never exceeds the table depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    FITS && out_valid |-> out_entry_count <= DEPTH_CNT)
    else $error("entry count beyond table depth");

endmodule

bind sorted_table_first_match_search stfm_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_stfm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_first_index (out_ch.first_index),
  .out_run_to_end  (out_ch.run_to_end),
  .out_entry_count (out_ch.entry_count)
);

// ===== tb/tb.sv =====
// testbench for the sorted key table with first-match search
// drives append, query, clear and unused requests and checks every result against a predictor
// depends on stfm_pkg, stfm_in_if, stfm_out_if and sorted_table_first_match_search
`timescale 1ns / 100ps

module tb;
  import stfm_pkg::*;

  localparam int TABLE_DEPTH   = DEF_TABLE_DEPTH;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int RANDOM_ITEMS  = 1180;
  localparam int DRAIN_CYCLES  = 24;
  localparam int IDLE_PERCENT  = 26;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  first_index;
    logic [COUNT_W-1:0]  run_to_end;
    logic [COUNT_W-1:0]  entry_count;
  } search_result_t;

  logic clk;
  logic rst_n;
  bit   calm;

  stfm_in_if  in_ch();
  stfm_out_if out_ch();

  sorted_table_first_match_search u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted table contents
  logic [KEY_W-1:0] held_keys [TABLE_DEPTH];
  int               held_count;
  logic [KEY_W-1:0] last_key;

  search_result_t pending_results[$];

  int mismatches;
  int results_seen;
  int requests_counted;
  int n_hits, n_misses, n_full, n_order, n_unused, deepest_table;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(10_000_000);
    $display("** sorted_table_first_match_search: FAILED **");
    $finish;
  end

  // predictor: applies one request to the table and returns its result
  function automatic search_result_t apply_request(input logic [ACTION_W-1:0] act,
                                                   input logic [KEY_W-1:0] k);
    search_result_t r;
    int lo, hi, mid;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_APPEND: begin
        if (held_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (k < last_key) begin
          r.status = ST_ORDER;
        end else begin
          held_keys[IDX_W'(held_count)] = k;
          held_count++;
          last_key = k;
        end
      end
      ACT_QUERY: begin
        // lower bound over the held entries
        lo = 0;
        hi = held_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (held_keys[IDX_W'(mid)] < k) lo = mid + 1;
          else hi = mid;
        end
        if (lo < held_count && held_keys[IDX_W'(lo)] == k) begin
          r.first_index = INDEX_W'(lo);
          r.run_to_end  = COUNT_W'(held_count - lo);
        end else begin
          r.status = ST_MISS;
        end
      end
      ACT_CLEAR: begin
        held_count = 0;
        last_key   = '0;
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(held_count);
    return r;
  endfunction

  // send one request, wait for acceptance, then record its expected result
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] k);
    search_result_t r;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid  <= 1'b0;
      in_ch.action <= ACTION_W'($urandom);
      in_ch.key    <= KEY_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.key    <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_request(act, k);
    pending_results.push_back(r);
    if (act != ACT_UNUSED) requests_counted++;
    else n_unused++;
    if (held_count > deepest_table) deepest_table = held_count;
    if (act == ACT_QUERY && r.status == ST_OK) n_hits++;
    case (r.status)
      ST_FULL:  n_full++;
      ST_ORDER: n_order++;
      ST_MISS:  n_misses++;
      default: ;
    endcase
  endtask

  // drop valid and wait until every expected result has come
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // query a held key most of the time, a neighbor or a random key otherwise
  task automatic send_query();
    logic [KEY_W-1:0] k;
    int pick;
    pick = $urandom_range(99);
    if (held_count > 0 && pick < 55) begin
      k = held_keys[IDX_W'($urandom_range(0, held_count - 1))];
    end else if (held_count > 0 && pick < 75) begin
      k = held_keys[IDX_W'($urandom_range(0, held_count - 1))];
      k = $urandom_range(1) ? k + 1'b1 : k - 1'b1;
    end else begin
      k = KEY_W'($urandom);
    end
    send_request(ACT_QUERY, k);
  endtask

  // next key of a non-decreasing run, saturating at the top
  function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k);
    int step;
    int r;
    r = $urandom_range(99);
    if (r < 35) step = 0;
    else if (r < 70) step = $urandom_range(1, 3);
    else step = $urandom_range(4, 4096);
    if (int'(k) + step > 65535) return '1;
    return KEY_W'(int'(k) + step);
  endfunction

  // queries and odd codes on an empty table, then appends to it
  task automatic test_empty_table();
    send_request(ACT_QUERY, 16'h0000);
    send_request(ACT_QUERY, 16'hFFFF);
    send_request(ACT_UNUSED, 16'hFFFF);
    send_request(ACT_CLEAR, 16'hFFFF);
    send_request(ACT_APPEND, 16'h0000);
    send_request(ACT_QUERY, 16'h0000);
  endtask

  // duplicates, both key extremes, misses, order refusal and clear
  task automatic test_append_and_query();
    send_request(ACT_CLEAR, 16'h0000);
    send_request(ACT_APPEND, 16'h0005);
    send_request(ACT_APPEND, 16'h0005);
    send_request(ACT_APPEND, 16'h0005);
    send_request(ACT_APPEND, 16'hFFFF);
    send_request(ACT_QUERY, 16'h0005);
    send_request(ACT_QUERY, 16'h0000);
    send_request(ACT_QUERY, 16'hFFFF);
    send_request(ACT_QUERY, 16'h0003);
    send_request(ACT_QUERY, 16'hFFFE);
    send_request(ACT_APPEND, 16'h0004);
    send_request(ACT_APPEND, 16'hFFFF);
    send_request(ACT_QUERY, 16'hFFFF);
    send_request(ACT_UNUSED, 16'h0005);
    send_request(ACT_CLEAR, 16'h1234);
    // any key goes into a cleared table
    send_request(ACT_APPEND, 16'h0001);
    send_request(ACT_QUERY, 16'h0001);
  endtask

  // sorted runs with random content mixed with queries, refusals and noise
  task automatic test_random_sequences();
    int start_count, done, run_len, r;
    bit paused;
    logic [KEY_W-1:0] k;
    start_count = requests_counted;
    paused = 1'b0;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      calm = (done >= 400 && done < 560);
      if (!paused && done >= 700) begin
        wait_until_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80) send_request(ACT_CLEAR, KEY_W'($urandom));
      run_len = ($urandom_range(9) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 24);
      k = KEY_W'($urandom);
      if ($urandom_range(1)) k = k >> $urandom_range(4, 15);
      for (int i = 0; i < run_len; i++) begin
        send_request(ACT_APPEND, k);
        r = $urandom_range(99);
        if (r < 30) send_query();
        else if (r < 36 && last_key != 0)
          send_request(ACT_APPEND, KEY_W'($urandom_range(0, int'(last_key) - 1)));
        else if (r < 40) send_request(ACT_UNUSED, KEY_W'($urandom));
        k = next_key(k);
      end
      repeat ($urandom_range(2, 10)) send_query();
      done = requests_counted - start_count;
    end
    calm = 1'b0;
  endtask

  // result side stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // result checker
  initial begin
    search_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no request pending: status %0d", out_ch.status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.first_index !== want.first_index) begin
            $error("first_index: expected %0d, got %0d", want.first_index, out_ch.first_index);
            mismatches++;
          end
          if (out_ch.run_to_end !== want.run_to_end) begin
            $error("run_to_end: expected %0d, got %0d", want.run_to_end, out_ch.run_to_end);
            mismatches++;
          end
          if (out_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, out_ch.entry_count);
            mismatches++;
          end
        end
      end
    end
  end

  // main sequence
  initial begin
    held_count = 0;
    last_key = '0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_APPEND;
    in_ch.key    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_append_and_query();
    wait_until_drained();
    test_random_sequences();
    wait_until_drained();

    $display("checked %0d results: %0d hits, %0d misses, %0d full and %0d order refusals,",
             results_seen, n_hits, n_misses, n_full, n_order);
    $display("%0d unused codes, deepest table %0d entries", n_unused, deepest_table);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** sorted_table_first_match_search: PASSED **");
    end else begin
      $display("** sorted_table_first_match_search: FAILED **");
    end
    $finish;
  end

endmodule
